// File: rtl/c2s_pkg.sv
`default_nettype none
package c2s_pkg;

   // working width of the rotation datapath and its binary point
   localparam int WORK_WIDTH  = 64;
   localparam int Q_POINT     = 60;
   // extra fraction bits carried on the angle accumulator
   localparam int ANGLE_GUARD = 8;
   // root bits of the planar length at Q_POINT scaling
   localparam int RHO_BITS    = Q_POINT + 1;

   typedef logic [WORK_WIDTH-1:0] word_type;

   // shift-subtract division, elaboration only
   function automatic longint unsigned div_u64(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = (r << 1) | ((a >> i) & 64'd1);
         q = q << 1;
         if (r >= b) begin
            r = r - b;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // atan(1/n) in Q60 by its series
   function automatic longint unsigned atan_inv_q60(longint unsigned n);
      longint unsigned t;
      longint unsigned sum;
      longint unsigned k;
      t   = div_u64(64'd1 << 60, n);
      sum = t;
      k   = 1;
      while (t != 0) begin
         t = div_u64(div_u64(t, n), n);
         if (k[0]) begin
            sum = sum - div_u64(t, 2 * k + 1);
         end else begin
            sum = sum + div_u64(t, 2 * k + 1);
         end
         k = k + 1;
      end
      return sum;
   endfunction

   // atan(2^-i)/pi scaled by 2^acc_bits, rounded to nearest
   function automatic longint unsigned atan_entry(int i, int acc_bits);
      longint unsigned pi_q;
      longint unsigned r;
      longint unsigned q;
      pi_q = 16 * atan_inv_q60(64'd5) - 4 * atan_inv_q60(64'd239);
      if (i == 0) begin
         return 64'd1 << (acc_bits - 2);
      end
      r = atan_inv_q60(64'd1 << i);
      q = 0;
      for (int j = 0; j <= acc_bits; j++) begin
         r = r << 1;
         q = q << 1;
         if (r >= pi_q) begin
            r = r - pi_q;
            q = q | 64'd1;
         end
      end
      return (q + 64'd1) >> 1;
   endfunction

endpackage
`default_nettype wire

// File: rtl/c2s_sqrt_pipe.sv
`default_nettype none
module c2s_sqrt_pipe #(
   parameter int RW = 16,
   parameter int SW = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [2*RW-1:0] in_value,
   input  wire logic [SW-1:0]   in_side,
   output logic                 out_valid,
   output logic [RW-1:0]        out_root,
   output logic [SW-1:0]        out_side
);
   import c2s_pkg::*;

   logic [2*RW-1:0] n_ff    [RW+1];
   logic [RW:0]     rem_ff  [RW+1];
   logic [RW-1:0]   root_ff [RW+1];
   logic [SW-1:0]   side_ff [RW+1];
   logic            v_ff    [RW+1];

   assign n_ff[0]    = in_value;
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign side_ff[0] = in_side;
   assign v_ff[0]    = in_valid;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW+1:0] rem2;
      logic [RW+1:0] trial;
      logic [RW+1:0] diff;
      logic          ge;
      logic [RW:0]   rem_in;
      logic [RW-1:0] root_in;

      always_comb begin
         rem2    = {rem_ff[k][RW-1:0], n_ff[k][2*RW-1 -: 2]};
         trial   = {root_ff[k], 2'b01};
         diff    = rem2 - trial;
         ge      = (rem2 >= trial);
         rem_in  = ge ? diff[RW:0] : rem2[RW:0];
         root_in = {root_ff[k][RW-2:0], ge};
      end

      // one root bit per stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            n_ff[k+1]    <= {n_ff[k][2*RW-3:0], 2'b00};
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];

endmodule
`default_nettype wire

// File: rtl/c2s_cordic_pipe.sv
`default_nettype none
module c2s_cordic_pipe #(
   parameter int STAGES = 32,
   parameter int AC     = 41,
   parameter int ACC    = 39,
   parameter int SW     = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [63:0]   in_px,
   input  wire logic signed [63:0]   in_py,
   input  wire logic [AC-1:0]        in_acc,
   input  wire logic [SW-1:0]        in_side,
   output logic                      out_valid,
   output logic [AC-1:0]             out_acc,
   output logic [SW-1:0]             out_side
);
   import c2s_pkg::*;

   logic signed [63:0] px_ff   [STAGES+1];
   logic signed [63:0] py_ff   [STAGES+1];
   logic [AC-1:0]      acc_ff  [STAGES+1];
   logic [SW-1:0]      side_ff [STAGES+1];
   logic               v_ff    [STAGES+1];

   assign px_ff[0]   = in_px;
   assign py_ff[0]   = in_py;
   assign acc_ff[0]  = in_acc;
   assign side_ff[0] = in_side;
   assign v_ff[0]    = in_valid;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam logic [63:0] TAB = 64'(atan_entry(k, ACC));
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] px_in;
      logic signed [63:0] py_in;
      logic [AC-1:0]      acc_in;

      always_comb begin
         dx = py_ff[k] >>> k;
         dy = px_ff[k] >>> k;
         if (!py_ff[k][63]) begin
            px_in  = px_ff[k] + dx;
            py_in  = py_ff[k] - dy;
            acc_in = acc_ff[k] + TAB[AC-1:0];
         end else begin
            px_in  = px_ff[k] - dx;
            py_in  = py_ff[k] + dy;
            acc_in = acc_ff[k] - TAB[AC-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            px_ff[k+1]   <= px_in;
            py_ff[k+1]   <= py_in;
            acc_ff[k+1]  <= acc_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[STAGES];
   assign out_acc   = acc_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule
`default_nettype wire

// File: rtl/cartesian_to_spherical.sv
// Stages from input beat to result beat: two square/sum stages,
// 61 root stages, the rotation stages, one output stage.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Latency is set by the root pipeline of the planar length, one bit per stage,
// and by the rotation stages.
// Reset clears every valid bit; data registers are not reset.
`default_nettype none
module cartesian_to_spherical #(
   parameter int COORD_WIDTH     = 32,
   parameter int ANGLE_WIDTH     = 32,
   parameter int ROTATION_STAGES = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  wire logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  wire logic signed [COORD_WIDTH-1:0] req_z_coord,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [COORD_WIDTH-1:0]             rsp_radius,
   output logic signed [ANGLE_WIDTH-1:0]      rsp_longitude,
   output logic signed [ANGLE_WIDTH-1:0]      rsp_latitude
);
   import c2s_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int PS  = Q_POINT - CW;           // coordinate pre-scale
   localparam int ACC = ANGLE_WIDTH - 1 + ANGLE_GUARD;
   localparam int AC  = ACC + 2;
   localparam int RRW = CW + 1;                 // radius root bits
   localparam int DLY = RHO_BITS - RRW;         // radius realignment

   // one enable for every stage: advance when the output slot is free
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: magnitudes squared
   logic [CW-1:0]   ax, ay, az;
   logic            v1_ff;
   logic [CW-1:0]   x1_ff, y1_ff, z1_ff;
   logic [2*CW-1:0] sqx_ff, sqy_ff, sqz_ff;

   always_comb begin
      ax = req_x_coord[CW-1] ? CW'(-req_x_coord) : CW'(req_x_coord);
      ay = req_y_coord[CW-1] ? CW'(-req_y_coord) : CW'(req_y_coord);
      az = req_z_coord[CW-1] ? CW'(-req_z_coord) : CW'(req_z_coord);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         x1_ff  <= req_x_coord;
         y1_ff  <= req_y_coord;
         z1_ff  <= req_z_coord;
         sqx_ff <= ax * ax;
         sqy_ff <= ay * ay;
         sqz_ff <= az * az;
      end
   end

   // stage 2: planar and full sums of squares
   logic            v2_ff;
   logic [CW-1:0]   x2_ff, y2_ff, z2_ff;
   logic [2*CW:0]   sqxy_ff;
   logic [2*CW+1:0] sqall_ff;
   logic            zxy2_ff;
   logic [2*CW:0]   sqxy_in;

   assign sqxy_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         z2_ff    <= z1_ff;
         sqxy_ff  <= sqxy_in;
         sqall_ff <= {1'b0, sqxy_in} + {2'b00, sqz_ff};
         zxy2_ff  <= (x1_ff == '0) && (y1_ff == '0);
      end
   end

   // roots: planar length at Q60 scale, and the radius
   logic                  rho_v;
   logic [RHO_BITS-1:0]   rho;
   logic [3*CW-1:0]       rho_side;
   logic                  rad_v;
   logic [RRW-1:0]        rad_root;
   logic                  rad_zxy;

   c2s_sqrt_pipe #(.RW(RHO_BITS), .SW(3*CW)) u_rho (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_value  ({1'b0, sqxy_ff, {(2*PS){1'b0}}}),
      .in_side   ({x2_ff, y2_ff, z2_ff}),
      .out_valid (rho_v),
      .out_root  (rho),
      .out_side  (rho_side)
   );

   c2s_sqrt_pipe #(.RW(RRW), .SW(1)) u_radius (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_value  (sqall_ff),
      .in_side   (zxy2_ff),
      .out_valid (rad_v),
      .out_root  (rad_root),
      .out_side  (rad_zxy)
   );

   // realign the shorter radius pipe with the planar root
   logic [CW:0] dly_ff [DLY+1];
   logic        dly_v_ff [DLY+1];
   assign dly_ff[0]   = {rad_root[CW-1:0], rad_zxy};
   assign dly_v_ff[0] = rad_v;
   for (genvar d = 0; d < DLY; d++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            dly_v_ff[d+1] <= 1'b0;
         end else if (en) begin
            dly_v_ff[d+1] <= dly_v_ff[d];
         end
         if (en) begin
            dly_ff[d+1] <= dly_ff[d];
         end
      end
   end

   // rotation set-up: fold negative x by pi for the longitude
   logic signed [63:0] xs, ys, zs;
   logic signed [63:0] lon_px, lon_py;
   logic [AC-1:0]      lon_acc0;
   logic               lat_zero;
   logic [CW-1:0]      xq, yq, zq;

   always_comb begin
      xq = rho_side[3*CW-1 -: CW];
      yq = rho_side[2*CW-1 -: CW];
      zq = rho_side[CW-1:0];
      xs = {{(64-CW){xq[CW-1]}}, xq} <<< PS;
      ys = {{(64-CW){yq[CW-1]}}, yq} <<< PS;
      zs = {{(64-CW){zq[CW-1]}}, zq} <<< PS;
      if (xs[63]) begin
         lon_px   = -xs;
         lon_py   = -ys;
         lon_acc0 = ys[63] ? AC'(-(AC'(1) << ACC)) : AC'(AC'(1) << ACC);
      end else begin
         lon_px   = xs;
         lon_py   = ys;
         lon_acc0 = '0;
      end
      lat_zero = (rho == '0) && (zq == '0);
   end

   logic          lon_v, lat_v;
   logic [AC-1:0] lon_acc, lat_acc;
   logic [CW:0]   lon_side;
   logic          lat_side;

   c2s_cordic_pipe #(.STAGES(ROTATION_STAGES), .AC(AC), .ACC(ACC), .SW(CW + 1)) u_lon (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rho_v && dly_v_ff[DLY]),
      .in_px     (lon_px),
      .in_py     (lon_py),
      .in_acc    (lon_acc0),
      .in_side   (dly_ff[DLY]),
      .out_valid (lon_v),
      .out_acc   (lon_acc),
      .out_side  (lon_side)
   );

   c2s_cordic_pipe #(.STAGES(ROTATION_STAGES), .AC(AC), .ACC(ACC), .SW(1)) u_lat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rho_v),
      .in_px     ({{(64-RHO_BITS){1'b0}}, rho}),
      .in_py     (zs),
      .in_acc    ('0),
      .in_side   (lat_zero),
      .out_valid (lat_v),
      .out_acc   (lat_acc),
      .out_side  (lat_side)
   );

   // output stage: round away the guard bits, force zero cases
   logic          rsp_valid_ff;
   logic [CW-1:0] radius_ff;
   logic [ANGLE_WIDTH-1:0] lon_ff, lat_ff;
   logic [AC-1:0] lon_rnd, lat_rnd;

   always_comb begin
      lon_rnd = lon_acc + AC'(AC'(1) << (ANGLE_GUARD - 1));
      lat_rnd = lat_acc + AC'(AC'(1) << (ANGLE_GUARD - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lon_v && lat_v;
      end
      if (en) begin
         radius_ff <= lon_side[CW:1];
         lon_ff    <= lon_side[0] ? '0 : lon_rnd[ANGLE_GUARD +: ANGLE_WIDTH];
         lat_ff    <= lat_side ? '0 : lat_rnd[ANGLE_GUARD +: ANGLE_WIDTH];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_radius    = radius_ff;
   assign rsp_longitude = lon_ff;
   assign rsp_latitude  = lat_ff;

endmodule
`default_nettype wire

// File: tb/sv/cartesian_to_spherical_test.sv
`timescale 1ns / 1ps
`default_nettype none
module cartesian_to_spherical_test;

   localparam int COORD_W    = 32;
   localparam int ANGLE_W    = 32;
   localparam int STAGES     = 32;
   localparam int GUARD      = 8;
   localparam int ACC_W      = ANGLE_W - 1 + GUARD;   // log2 of accumulator units per pi
   localparam int PRE_SHIFT  = 60 - COORD_W;
   localparam int DRAIN      = STAGES + 80;           // beyond the pipeline latency
   localparam int STALL_MAX  = 4000;                  // cycles with no beat at all

   typedef struct packed {
      logic [COORD_W-1:0]        radius;
      logic signed [ANGLE_W-1:0] longitude;
      logic signed [ANGLE_W-1:0] latitude;
   } sph_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic signed [COORD_W-1:0] req_z_coord = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [COORD_W-1:0]        rsp_radius;
   logic signed [ANGLE_W-1:0] rsp_longitude;
   logic signed [ANGLE_W-1:0] rsp_latitude;

   cartesian_to_spherical #(
      .COORD_WIDTH(COORD_W), .ANGLE_WIDTH(ANGLE_W), .ROTATION_STAGES(STAGES)
   ) dut (.*);

   // percentage of cycles in which each side holds off
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   sph_type     pending_coords[$];
   longint      atan_steps[STAGES];
   int unsigned failures = 0;
   int unsigned beats_in = 0;
   int unsigned beats_out = 0;
   int unsigned quiet_cycles = 0;

   initial forever #5 clock = ~clock;

   // atan(1/n) in Q60 from its power series
   function automatic longint unsigned atan_recip(longint unsigned n);
      longint unsigned term, total, k;
      term  = (64'd1 << 60) / n;
      total = term;
      k     = 1;
      while (term != 0) begin
         term = term / n / n;
         if (k[0]) total -= term / (2 * k + 1);
         else total += term / (2 * k + 1);
         k++;
      end
      return total;
   endfunction

   // arctangent steps in accumulator units, pi from Machin's formula
   initial begin
      longint unsigned pi_q, rem, quo;
      pi_q = 16 * atan_recip(5) - 4 * atan_recip(239);
      atan_steps[0] = longint'(64'd1 << (ACC_W - 2));
      for (int i = 1; i < STAGES; i++) begin
         rem = atan_recip(64'd1 << i);
         quo = 0;
         for (int j = 0; j <= ACC_W; j++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= pi_q) begin
               rem -= pi_q;
               quo |= 1;
            end
         end
         atan_steps[i] = longint'((quo + 1) >> 1);
      end
   end

   function automatic logic [63:0] floor_root(logic [127:0] n);
      logic [63:0] r, c;
      r = '0;
      for (int b = 61; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   // vectoring rotation: drive py to zero, return rounded angle
   function automatic logic [ANGLE_W-1:0] vector_angle(longint px, longint py, longint acc);
      longint dx, dy;
      for (int i = 0; i < STAGES; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px += dx; py -= dy; acc += atan_steps[i];
         end else begin
            px -= dx; py += dy; acc -= atan_steps[i];
         end
      end
      return ANGLE_W'((acc + (64'sd1 <<< (GUARD - 1))) >>> GUARD);
   endfunction

   function automatic sph_type to_spherical(logic signed [COORD_W-1:0] xi,
                                            logic signed [COORD_W-1:0] yi,
                                            logic signed [COORD_W-1:0] zi);
      sph_type     res;
      longint      x, y, z, xs, ys, zs, acc, rho;
      logic [127:0] sq_xy, sq_all;
      x = xi; y = yi; z = zi;
      sq_xy  = 128'(x * x) + 128'(y * y);
      sq_all = sq_xy + 128'(z * z);
      res.radius = COORD_W'(floor_root(sq_all));
      xs = x <<< PRE_SHIFT;
      ys = y <<< PRE_SHIFT;
      zs = z <<< PRE_SHIFT;
      if (x == 0 && y == 0) begin
         res.longitude = '0;
      end else begin
         acc = 0;
         // left half-plane: turn by pi first, sign of y picks +pi or -pi
         if (xs < 0) begin
            acc = (ys >= 0) ? (64'sd1 <<< ACC_W) : -(64'sd1 <<< ACC_W);
            xs = -xs;
            ys = -ys;
         end
         res.longitude = vector_angle(xs, ys, acc);
      end
      rho = longint'(floor_root(sq_xy << (2 * PRE_SHIFT)));
      if (rho == 0 && z == 0) res.latitude = '0;
      else res.latitude = vector_angle(rho, zs, 0);
      return res;
   endfunction

   // receiver: stall at the current rate
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // predict on every accepted input beat, check every accepted result beat
   always @(posedge clock) begin
      sph_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_coords.push_back(to_spherical(req_x_coord, req_y_coord, req_z_coord));
            beats_in++;
         end
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (pending_coords.size() == 0) begin
               $error("result beat with nothing outstanding");
               failures++;
            end else begin
               want = pending_coords.pop_front();
               if (rsp_radius !== want.radius) begin
                  $error("radius: expected %0d, got %0d", want.radius, rsp_radius);
                  failures++;
               end
               if (rsp_longitude !== want.longitude) begin
                  $error("longitude: expected %0d, got %0d", want.longitude, rsp_longitude);
                  failures++;
               end
               if (rsp_latitude !== want.latitude) begin
                  $error("latitude: expected %0d, got %0d", want.latitude, rsp_latitude);
                  failures++;
               end
            end
         end
         // watchdog: count cycles with no beat on either side while work is outstanding
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else if (pending_coords.size() != 0 || req_valid) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
               $display("cartesian_to_spherical test failed");
               $finish;
            end
         end
      end
   end

   // offer one position and hold it until the beat is taken
   task automatic send_position(logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(5))
         0: return '0;
         1: return COORD_W'($signed($urandom_range(0, 2000)) - 1000);
         2: return $urandom_range(1) ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
         3: return COORD_W'($signed($urandom() >> $urandom_range(31)));
         default: return COORD_W'($urandom());
      endcase
   endfunction

   task automatic test_extremes();
      logic signed [COORD_W-1:0] hi, lo;
      hi = {1'b0, {(COORD_W-1){1'b1}}};
      lo = {1'b1, {(COORD_W-1){1'b0}}};
      send_position(0, 0, 0);          // zero vector
      send_position(0, 0, 1);          // on the pole
      send_position(0, 0, -1);
      send_position(0, 0, lo);
      send_position(1, 0, 0);
      send_position(-1, 0, 0);         // longitude of pi
      send_position(lo, 0, 0);
      send_position(-5, 1, 0);         // left half-plane, upper
      send_position(-5, -1, 0);        // left half-plane, lower
      send_position(0, 7, 0);          // x zero, y non-zero
      send_position(0, -7, 3);
      send_position(hi, hi, hi);
      send_position(lo, lo, lo);
      send_position(lo, hi, lo);
      send_position(hi, lo, hi);
      send_position(-1, -1, -1);
      send_position(3, 4, 12);
      send_position(lo, lo, 0);
      send_position(hi, 0, lo);
      send_position(0, lo, hi);
   endtask

   task automatic test_random(int unsigned count);
      logic signed [COORD_W-1:0] x, y, z;
      repeat (count) begin
         x = pick_coord();
         y = pick_coord();
         z = pick_coord();
         send_position(x, y, z);
      end
   endtask

   task automatic finish_stream();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_coords.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender mostly offering, receiver mostly stalled
      send_idle_pct  = 22;
      recv_stall_pct = 58;
      test_extremes();
      test_random(180);
      // swap the pressure
      send_idle_pct  = 58;
      recv_stall_pct = 22;
      test_random(180);
      // back to back
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random(190);

      finish_stream();
      $display("covered %0d positions in, %0d results out across three pacing phases",
               beats_in, beats_out);
      $display("including axes, poles, the pi wrap and full-scale corners");
      if (failures == 0 && pending_coords.size() == 0)
         $display("cartesian_to_spherical test passed");
      else
         $display("cartesian_to_spherical test failed");
      $finish;
   end

endmodule
`default_nettype wire

// File: cartesian_to_spherical.f
rtl/c2s_pkg.sv
rtl/c2s_sqrt_pipe.sv
rtl/c2s_cordic_pipe.sv
rtl/cartesian_to_spherical.sv
tb/sv/cartesian_to_spherical_test.sv
